// ===== design/trtc_pkg.sv =====
// Shared types, codes and the month table for the tick RTC with date loader.
// No dependencies; imported by the date converter and the top level.
package trtc_pkg;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_EPOCH = 2'd1,
    OP_SET_DATE  = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  localparam logic [1:0] CFG_TICK_MS          = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd1;

  localparam logic [9:0] TICK_MS_RESET          = 10'd10;
  localparam logic [9:0] TICKS_PER_SECOND_RESET = 10'd100;

  localparam logic [6:0]  MIN_YEAR        = 7'd7;
  localparam logic [7:0]  YEARS_1970_2000 = 8'd30;
  localparam logic [31:0] DAYS_PER_YEAR   = 32'd365;
  localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR   = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN    = 32'd60;

  typedef struct packed {
    logic [5:0] second_num;
    logic [5:0] minute_num;
    logic [4:0] hour_num;
    logic [4:0] day_of_month;
    logic [3:0] month_num;
    logic [6:0] year_in_century;
  } date_t;

  function automatic logic [8:0] month_offset(input logic [3:0] month,
                                              input logic [6:0] year);
    logic [8:0] d;
    case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if ((month inside {[4'd3:4'd12]}) && (year[1:0] == 2'd0)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

// ===== design/trtc_date_conv.sv =====
// Calendar date after 2000 to Unix seconds, with early-year rejection.
// Depends on trtc_pkg for the date struct, constants and month table.
module trtc_date_conv import trtc_pkg::*; (
  input  date_t       date,
  output logic [31:0] epoch,
  output logic        rejected
);

  logic [7:0]  since1970;
  logic [7:0]  leap_base;
  logic [31:0] days;

  always_comb begin
    since1970 = {1'b0, date.year_in_century} + YEARS_1970_2000;
    leap_base = since1970 + 8'd1;
    days = 32'(since1970) * DAYS_PER_YEAR
         + 32'(leap_base[7:2])
         + 32'(month_offset(date.month_num, date.year_in_century))
         + 32'(date.day_of_month)
         - 32'd1;
    epoch = days * SECS_PER_DAY
          + 32'(date.hour_num) * SECS_PER_HOUR
          + 32'(date.minute_num) * SECS_PER_MIN
          + 32'(date.second_num);
    rejected = (date.year_in_century < MIN_YEAR);
  end

endmodule

// ===== design/tick_rtc_with_date_to_epoch_top.sv =====
// Tick RTC with calendar-date loader: millisecond counter, tick divider, seconds clock.
// Each beat passes an input register (v0) and then a result register (m_tvalid, m_tdata).
// One beat per cycle unless m_tready stalls; conversion and state update sit in between.
// Reset (rst, synchronous): counters and divider to zero, tick_ms 10, ticks_per_second 100.
// Depends on trtc_pkg and trtc_date_conv.
module tick_rtc_with_date_to_epoch_top import trtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // epoch_value[31:0], year_in_century[38:32], month_num[42:39], day_of_month[47:43],
  // hour_num[52:48], minute_num[58:53], second_num[64:59], zero[71:65]
  input  logic [71:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // millis_now[31:0], epoch_now[63:32]
  output logic [63:0] m_tdata,
  // date_rejected[0]
  output logic        m_tuser
);

  logic [9:0]  tick_ms;
  logic [9:0]  ticks_per_second;
  logic [31:0] millisecond_count;
  logic [9:0]  tick_divider;
  logic [31:0] epoch_seconds;

  logic        v0;
  op_t         op0;
  logic [31:0] epoch_value0;
  date_t       date0;

  logic        load_out;
  logic [31:0] date_epoch;
  logic        date_rej;
  logic        load_epoch;
  logic [31:0] load_value;
  logic        date_rejected;

  logic [31:0] millis_next;
  logic [9:0]  divider_next;
  logic [31:0] epoch_next;
  logic [9:0]  limit;

  assign cfg_ready = 1'b1;
  assign load_out  = v0 && (!m_tvalid || m_tready);
  assign s_tready  = !v0 || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms          <= TICK_MS_RESET;
      ticks_per_second <= TICKS_PER_SECOND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TICK_MS:          tick_ms <= cfg_data;
        CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (s_tready) begin
      v0 <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      op0          <= op_t'(s_tuser);
      epoch_value0 <= s_tdata[31:0];
      date0        <= date_t'(s_tdata[64:32]);
    end
  end

  trtc_date_conv u_date_conv (
    .date     (date0),
    .epoch    (date_epoch),
    .rejected (date_rej)
  );

  always_comb begin
    limit         = (ticks_per_second == 10'd0) ? 10'd0 : ticks_per_second - 10'd1;
    load_epoch    = (op0 == OP_SET_EPOCH) || ((op0 == OP_SET_DATE) && !date_rej);
    load_value    = (op0 == OP_SET_EPOCH) ? epoch_value0 : date_epoch;
    date_rejected = (op0 == OP_SET_DATE) && date_rej;
    millis_next   = millisecond_count;
    divider_next  = tick_divider;
    epoch_next    = epoch_seconds;
    if (op0 == OP_TICK) begin
      millis_next = millisecond_count + 32'(tick_ms);
      if (tick_divider >= limit) begin
        divider_next = 10'd0;
        epoch_next   = epoch_seconds + 32'd1;
      end else begin
        divider_next = tick_divider + 10'd1;
      end
    end else if (load_epoch) begin
      epoch_next = load_value;
    end
  end

  // Result stage and clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid          <= 1'b0;
      millisecond_count <= 32'd0;
      tick_divider      <= 10'd0;
      epoch_seconds     <= 32'd0;
    end else begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= v0;
      end
      if (load_out) begin
        millisecond_count <= millis_next;
        tick_divider      <= divider_next;
        epoch_seconds     <= epoch_next;
      end
    end
    if (load_out) begin
      m_tdata <= {epoch_next, millis_next};
      m_tuser <= date_rejected;
    end
  end

endmodule
